@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define HKVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define HKVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/hkvt_pkg.sv @@
`default_nettype none

package hkvt_pkg;

    // Fixed field widths of the request and response.
    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;

    // Default sizing of the table.
    localparam int BUCKETS_DEF    = 256;
    localparam int WAYS_DEF       = 4;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Request opcodes. The fourth code is a no-op.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    // One request.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    req_key;
        logic [VALUE_W-1:0]  req_value;
    } t_kv_req;

    // One response.
    typedef struct packed {
        logic               success;
        logic               bucket_full;
        logic [VALUE_W-1:0] read_value;
    } t_kv_rsp;

endpackage

`default_nettype wire

@@ rtl/hashed_key_value_table_core.sv @@
`default_nettype none
`include "assert_macros.svh"

// Key-value table with BUCKETS buckets of WAYS entries each; the bucket of a key is the key
// modulo BUCKETS. A request is transferred when start is high and busy is low. Its response
// appears on o_rsp for exactly one cycle with o_done high, and must be taken in that cycle.
// From transfer to response, a request runs through the multiplier steps, the read of way
// zero, a scan of 1 to WAYS ways (the scan stops at the first matching key) and a commit. The
// next request can be transferred in the response cycle. The sequence is paced by one shared
// multiplier, which runs three passes per request (quotient estimate of the bucket,
// back-multiply for the remainder, row base address), and by the entry memory, which delivers
// one way per cycle to a single key comparator. After reset, busy stays high while the
// valid-bit memory is cleared one bucket row per cycle.
module hashed_key_value_table_core #(
    parameter int BUCKETS    = hkvt_pkg::BUCKETS_DEF,
    parameter int WAYS       = hkvt_pkg::WAYS_DEF,
    parameter int KEY_BITS   = hkvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = hkvt_pkg::VALUE_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  wire hkvt_pkg::t_kv_req i_req,
    output logic              busy,
    output logic              o_done,
    output hkvt_pkg::t_kv_rsp o_rsp
);
    import hkvt_pkg::*;

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MUL_W   = 33;
    localparam int EDAT_W  = KEY_BITS + VALUE_BITS;

    // Fixed-point reciprocal of the bucket count, floor(2^32 / BUCKETS).
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(64'h1_0000_0000 / BUCKETS);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b0_0000_0001,
        S_IDLE   = 9'b0_0000_0010,
        S_MUL1   = 9'b0_0000_0100,
        S_MUL2   = 9'b0_0000_1000,
        S_MOD    = 9'b0_0001_0000,
        S_BASE   = 9'b0_0010_0000,
        S_READ   = 9'b0_0100_0000,
        S_SCAN   = 9'b0_1000_0000,
        S_COMMIT = 9'b1_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [BKT_W-1:0]      r_clr;
    logic                  r_done;
    t_kv_rsp               r_rsp;

    logic [OPCODE_W-1:0]   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [2*MUL_W-1:0]    r_prod;
    logic [BKT_W-1:0]      r_bucket;
    logic [ENT_W-1:0]      r_base;
    logic [WAY_W-1:0]      r_way;
    logic                  r_hit;
    logic [WAY_W-1:0]      r_hit_way;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic                  r_free;
    logic [WAY_W-1:0]      r_free_way;

    logic [WAYS-1:0]       r_vmem [BUCKETS];
    logic [WAYS-1:0]       r_vrow;
    logic [EDAT_W-1:0]     r_emem [ENTRIES];
    logic [EDAT_W-1:0]     r_erd;

    logic                  w_accept;
    logic [63:0]           w_in_key64;
    logic [63:0]           w_in_val64;
    logic [63:0]           w_key64;
    logic [KEY_W-1:0]      w_hkey;
    logic [MUL_W-1:0]      w_mul_a;
    logic [MUL_W-1:0]      w_mul_b;
    logic [2*MUL_W-1:0]    w_prod;
    logic [KEY_W-1:0]      w_rem0;
    logic [KEY_W-1:0]      w_rem;
    logic [KEY_BITS-1:0]   w_erd_key;
    logic [VALUE_BITS-1:0] w_erd_val;
    logic                  w_way_hit;
    logic                  w_last_way;
    logic [WAY_W-1:0]      w_way_next;
    logic                  w_ere;
    logic [ENT_W-1:0]      w_eraddr;
    logic                  w_ewe;
    logic [ENT_W-1:0]      w_ewaddr;
    logic                  w_vwe;
    logic [BKT_W-1:0]      w_vwaddr;
    logic [WAYS-1:0]       w_vwdata;
    logic [WAYS-1:0]       n_vrow;
    logic                  w_is_ins;
    logic                  w_is_get;
    logic                  w_is_rem;
    logic                  w_ins_ok;
    logic                  w_get_ok;
    logic                  w_rem_ok;
    logic [63:0]           w_hit_val64;
    t_kv_rsp               n_rsp;

    // Handshake.
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Key and value are taken in their low KEY_BITS and VALUE_BITS bits.
    assign w_in_key64 = 64'(i_req.req_key);
    assign w_in_val64 = 64'(i_req.req_value);
    assign w_key64    = 64'(r_key);
    assign w_hkey     = w_key64[KEY_W-1:0];

    // Shared multiplier: quotient estimate, back-multiply, then row base address.
    always_comb begin
        case (r_state)
            S_MUL1: begin
                w_mul_a = MUL_W'(w_hkey);
                w_mul_b = RECIP;
            end
            S_MUL2: begin
                w_mul_a = MUL_W'(r_prod[2*KEY_W-1:KEY_W]);
                w_mul_b = MUL_W'(BUCKETS);
            end
            S_BASE: begin
                w_mul_a = MUL_W'(r_bucket);
                w_mul_b = MUL_W'(WAYS);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // The estimated quotient is low by at most one, so one correction finishes the remainder.
    assign w_rem0 = w_hkey - r_prod[KEY_W-1:0];
    assign w_rem  = ((KEY_W+1)'(w_rem0) >= (KEY_W+1)'(BUCKETS)) ?
                    (w_rem0 - KEY_W'(BUCKETS)) : w_rem0;

    // Way comparator on the entry just read.
    assign w_erd_key  = r_erd[EDAT_W-1:VALUE_BITS];
    assign w_erd_val  = r_erd[VALUE_BITS-1:0];
    assign w_way_hit  = r_vrow[r_way] && (w_erd_key == r_key);
    assign w_last_way = (r_way == WAY_W'(WAYS - 1));
    assign w_way_next = r_way + 1'b1;

    // Entry read: way zero from the read state, then the following way while scanning.
    assign w_ere    = (r_state == S_READ) ||
                      ((r_state == S_SCAN) && !w_last_way && !w_way_hit);
    assign w_eraddr = r_base + ((r_state == S_SCAN) ? ENT_W'(w_way_next) : '0);

    // Decode of the finished search.
    assign w_is_ins = (r_op == OP_INSERT);
    assign w_is_get = (r_op == OP_GET);
    assign w_is_rem = (r_op == OP_REMOVE);
    assign w_ins_ok = w_is_ins && !r_hit && r_free;
    assign w_get_ok = w_is_get && r_hit;
    assign w_rem_ok = w_is_rem && r_hit;

    // Updated valid row of the bucket.
    always_comb begin
        n_vrow = r_vrow;
        if (w_ins_ok) begin
            n_vrow[r_free_way] = 1'b1;
        end
        if (w_rem_ok) begin
            n_vrow[r_hit_way] = 1'b0;
        end
    end

    // Entry write of an insert.
    assign w_ewe    = (r_state == S_COMMIT) && w_ins_ok;
    assign w_ewaddr = r_base + ENT_W'(r_free_way);

    // Valid-row writes: the clearing pass after reset, then commits.
    assign w_vwe    = (r_state == S_CLEAR) ||
                      ((r_state == S_COMMIT) && (w_ins_ok || w_rem_ok));
    assign w_vwaddr = (r_state == S_CLEAR) ? r_clr : r_bucket;
    assign w_vwdata = (r_state == S_CLEAR) ? '0 : n_vrow;

    // Response of the finished request.
    assign w_hit_val64 = 64'(r_hit_val);
    always_comb begin
        n_rsp             = '0;
        n_rsp.success     = w_ins_ok || w_get_ok || w_rem_ok;
        n_rsp.bucket_full = w_is_ins && !r_hit && !r_free;
        if (w_get_ok) begin
            n_rsp.read_value = w_hit_val64[VALUE_W-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_MOD;
            S_MOD:    n_state = S_BASE;
            S_BASE:   n_state = S_READ;
            S_READ:   n_state = S_SCAN;
            S_SCAN: begin
                if (w_way_hit || w_last_way) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_COMMIT);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Request, arithmetic and search registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.opcode;
            r_key <= w_in_key64[KEY_BITS-1:0];
            r_val <= w_in_val64[VALUE_BITS-1:0];
        end
        if ((r_state == S_MUL1) || (r_state == S_MUL2)) begin
            r_prod <= w_prod;
        end
        if (r_state == S_MOD) begin
            r_bucket <= w_rem[BKT_W-1:0];
        end
        if (r_state == S_BASE) begin
            r_base <= w_prod[ENT_W-1:0];
        end
        if (r_state == S_READ) begin
            r_way  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (w_way_hit) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_way;
                r_hit_val <= w_erd_val;
            end
            if (!r_vrow[r_way] && !r_free) begin
                r_free     <= 1'b1;
                r_free_way <= r_way;
            end
            if (!w_last_way) begin
                r_way <= w_way_next;
            end
        end
        if (r_state == S_COMMIT) begin
            r_rsp <= n_rsp;
        end
    end

    // Valid-row memory, one row per bucket.
    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_vmem[w_vwaddr] <= w_vwdata;
        end
        if (r_state == S_BASE) begin
            r_vrow <= r_vmem[r_bucket];
        end
    end

    // Entry memory, key and value of each way.
    always_ff @(posedge i_clk) begin
        if (w_ewe) begin
            r_emem[w_ewaddr] <= {r_key, r_val};
        end
        if (w_ere) begin
            r_erd <= r_emem[w_eraddr];
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // A response only follows the commit step.
    `HKVT_ASSERT(a_done_after_commit, i_clk, i_rst_n, o_done |-> $past(r_state == S_COMMIT), "response without commit")
    // An insert cannot both succeed and report a full bucket.
    `HKVT_ASSERT(a_rsp_exclusive, i_clk, i_rst_n, o_done |-> !(o_rsp.success && o_rsp.bucket_full), "success and bucket_full together")
    // The remainder correction keeps the bucket in range.
    `HKVT_ASSERT(a_bucket_range, i_clk, i_rst_n, (r_state == S_READ) |-> (r_bucket < BUCKETS), "bucket out of range")
    // The way counter never runs past the bucket.
    `HKVT_ASSERT(a_way_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_way < WAYS), "way out of range")
    // The held request does not change while a request is in progress.
    `HKVT_ASSERT(a_req_held, i_clk, i_rst_n, (busy && $past(busy) && (r_state != S_CLEAR)) |-> $stable(r_key), "request changed while busy")

endmodule

`default_nettype wire
